FILE: rtl/vpw_pulse_width_decoder_assert.svh
// assertion helpers shared by the receiver modules
`ifndef VPW_PULSE_WIDTH_DECODER_ASSERT_SVH
`define VPW_PULSE_WIDTH_DECODER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define VPW_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vpw assertion failed in the same cycle");

// consequent must hold in the cycle after the antecedent
`define VPW_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vpw assertion failed one cycle later");

`endif

FILE: rtl/vpw_pkg.sv
package vpw_pkg;

  localparam int VPW_TS_W        = 16;
  localparam int VPW_REG_IDX_W   = 3;
  localparam int VPW_QUEUE_DEPTH = 2;

  // register reset values
  localparam logic [VPW_TS_W-1:0] VPW_SOF_MIN_RST   = 16'd163;
  localparam logic [VPW_TS_W-1:0] VPW_SOF_MAX_RST   = 16'd239;
  localparam logic [VPW_TS_W-1:0] VPW_LONG_MIN_RST  = 16'd96;
  localparam logic [VPW_TS_W-1:0] VPW_LONG_MAX_RST  = 16'd163;
  localparam logic [VPW_TS_W-1:0] VPW_SHORT_MIN_RST = 16'd34;
  localparam logic [VPW_TS_W-1:0] VPW_SHORT_MAX_RST = 16'd96;
  localparam logic [VPW_TS_W-1:0] VPW_MODULUS_RST   = 16'd65535;

  localparam logic [2:0] VPW_BIT_POS_TOP = 3'd7;
  localparam logic [7:0] VPW_COUNT_MAX   = 8'd255;

  // register indexes on the config port
  typedef enum logic [VPW_REG_IDX_W-1:0] {
    REG_SOF_MIN         = 3'd0,
    REG_SOF_MAX         = 3'd1,
    REG_LONG_MIN        = 3'd2,
    REG_LONG_MAX        = 3'd3,
    REG_SHORT_MIN       = 3'd4,
    REG_SHORT_MAX       = 3'd5,
    REG_COUNTER_MODULUS = 3'd6
  } vpw_reg_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_START = 2'd2
  } vpw_kind_t;

  // operations handed from front to back
  typedef enum logic [1:0] {
    OP_END   = 2'd0,
    OP_SOF   = 2'd1,
    OP_LONG  = 2'd2,
    OP_SHORT = 2'd3
  } vpw_op_t;

  // input command codes
  localparam logic CMD_EDGE    = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic [VPW_TS_W-1:0] timestamp;
  } vpw_in_t;

  typedef struct packed {
    vpw_kind_t  kind;
    logic [7:0] data_byte;
    logic [7:0] frame_bytes;
  } vpw_out_t;

  typedef struct packed {
    logic [VPW_TS_W-1:0] sof_min;
    logic [VPW_TS_W-1:0] sof_max;
    logic [VPW_TS_W-1:0] long_min;
    logic [VPW_TS_W-1:0] long_max;
    logic [VPW_TS_W-1:0] short_min;
    logic [VPW_TS_W-1:0] short_max;
    logic [VPW_TS_W-1:0] counter_modulus;
  } vpw_cfg_t;

endpackage

FILE: rtl/vpw_pulse_width_decoder.sv
// path: a request passes the classify stage register, the op queue and the output register
// throughput: one request per cycle while the op queue is not full; the output register and a small op queue
//   between the classify front and the bit-assembly back keep either side moving
// reset (rst, synchronous, active high): registers return to defaults,
//   receiver idle, symbol history short/1, bit position 7, counts cleared
module vpw_pulse_width_decoder import vpw_pkg::*; #(
  parameter int QUEUE_DEPTH = VPW_QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  vpw_in_t                  in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output vpw_out_t                 out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [VPW_REG_IDX_W-1:0] cfg_index,
  input  logic [VPW_TS_W-1:0]      cfg_data
);

  vpw_cfg_t cfg;
  logic     push;
  vpw_op_t  push_op;
  logic     q_full;
  logic     q_not_empty;
  logic     pop;
  vpw_op_t  pop_op;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sof_min         <= VPW_SOF_MIN_RST;
      cfg.sof_max         <= VPW_SOF_MAX_RST;
      cfg.long_min        <= VPW_LONG_MIN_RST;
      cfg.long_max        <= VPW_LONG_MAX_RST;
      cfg.short_min       <= VPW_SHORT_MIN_RST;
      cfg.short_max       <= VPW_SHORT_MAX_RST;
      cfg.counter_modulus <= VPW_MODULUS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SOF_MIN:         cfg.sof_min         <= cfg_data;
        REG_SOF_MAX:         cfg.sof_max         <= cfg_data;
        REG_LONG_MIN:        cfg.long_min        <= cfg_data;
        REG_LONG_MAX:        cfg.long_max        <= cfg_data;
        REG_SHORT_MIN:       cfg.short_min       <= cfg_data;
        REG_SHORT_MAX:       cfg.short_max       <= cfg_data;
        REG_COUNTER_MODULUS: cfg.counter_modulus <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // measure and classify
  vpw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .push     (push),
    .push_op  (push_op),
    .q_full   (q_full)
  );

  // op queue between the two halves
  vpw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (pop),
    .pop_op    (pop_op)
  );

  // bit assembly and results
  vpw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_op        (pop_op),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

FILE: rtl/vpw_queue.sv
`include "vpw_pulse_width_decoder_assert.svh"

module vpw_queue import vpw_pkg::*; #(
  parameter int DEPTH = VPW_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  vpw_op_t push_op,
  output logic    full,
  output logic    not_empty,
  input  logic    pop,
  output vpw_op_t pop_op
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  vpw_op_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_op    = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `VPW_ASSERT_NOW(a_q_no_underflow, clk, rst, pop, count != '0)
  `VPW_ASSERT_NOW(a_q_no_overflow, clk, rst, push && !pop, count != CNT_W'(DEPTH))

endmodule

FILE: rtl/vpw_front.sv
`include "vpw_pulse_width_decoder_assert.svh"

module vpw_front import vpw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  vpw_cfg_t cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  vpw_in_t  in_data,
  output logic     push,
  output vpw_op_t  push_op,
  input  logic     q_full
);

  logic                rx_active;
  logic [VPW_TS_W-1:0] prev_edge_time;

  // classify stage
  logic                st_valid;
  logic                st_cmd;
  logic                st_measure;
  logic [VPW_TS_W-1:0] st_width;

  logic                in_fire;
  logic                st_adv;
  logic                need_push;
  logic                in_sof;
  logic                in_long;
  logic                in_short;
  logic [VPW_TS_W:0]   diff;
  logic [VPW_TS_W-1:0] width_next;

  // width from previous edge, wrapped at the modulus when the stamp went back
  always_comb begin
    diff       = {1'b0, in_data.timestamp} - {1'b0, prev_edge_time};
    width_next = diff[VPW_TS_W-1:0] + (diff[VPW_TS_W] ? cfg.counter_modulus : '0);
  end

  // window compares
  assign in_sof   = (st_width > cfg.sof_min)   && (st_width <= cfg.sof_max);
  assign in_long  = (st_width > cfg.long_min)  && (st_width <= cfg.long_max);
  assign in_short = (st_width > cfg.short_min) && (st_width <= cfg.short_max);

  // sof wins, then long, then short
  always_comb begin
    push_op   = OP_END;
    need_push = 1'b0;
    if (st_cmd) begin
      push_op   = OP_END;
      need_push = 1'b1;
    end else if (st_measure) begin
      if (in_sof) begin
        push_op   = OP_SOF;
        need_push = 1'b1;
      end else if (in_long) begin
        push_op   = OP_LONG;
        need_push = 1'b1;
      end else if (in_short) begin
        push_op   = OP_SHORT;
        need_push = 1'b1;
      end
    end
  end

  assign push     = st_valid && need_push && !q_full;
  assign st_adv   = st_valid && (!need_push || !q_full);
  assign in_ready = !st_valid || st_adv;
  assign in_fire  = in_valid && in_ready;

  // stage control and edge tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid       <= 1'b0;
      rx_active      <= 1'b0;
      prev_edge_time <= '0;
    end else begin
      if (in_fire) begin
        st_valid <= 1'b1;
      end else if (st_adv) begin
        st_valid <= 1'b0;
      end
      if (in_fire) begin
        if (in_data.cmd == CMD_TIMEOUT) begin
          rx_active <= 1'b0;
        end else begin
          rx_active      <= 1'b1;
          prev_edge_time <= in_data.timestamp;
        end
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      st_cmd     <= in_data.cmd;
      st_measure <= rx_active;
      st_width   <= width_next;
    end
  end

  `VPW_ASSERT_NEXT(a_timeout_goes_idle, clk, rst,
                   in_fire && in_data.cmd == CMD_TIMEOUT, !rx_active)

endmodule

FILE: rtl/vpw_back.sv
`include "vpw_pulse_width_decoder_assert.svh"

module vpw_back import vpw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_not_empty,
  input  vpw_op_t  q_op,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_ready,
  output vpw_out_t out_data
);

  logic       last_bit;
  logic       last_symbol;
  logic [2:0] bit_position;
  logic [7:0] byte_accumulator;
  logic [7:0] byte_count;

  logic       last_bit_next;
  logic       last_symbol_next;
  logic [2:0] bit_position_next;
  logic [7:0] byte_accumulator_next;
  logic [7:0] byte_count_next;
  logic       load;
  vpw_out_t   result;
  logic       sym;
  logic       bit_val;
  logic [7:0] acc_or;
  logic [7:0] count_inc;

  assign pop = q_not_empty && (!out_valid || out_ready);

  // execute one operation
  always_comb begin
    last_bit_next         = last_bit;
    last_symbol_next      = last_symbol;
    bit_position_next     = bit_position;
    byte_accumulator_next = byte_accumulator;
    byte_count_next       = byte_count;
    load                  = 1'b0;
    result                = '{kind: KIND_BYTE, data_byte: 8'd0, frame_bytes: 8'd0};
    sym                   = (q_op == OP_SHORT);
    bit_val               = (sym == last_symbol) ? !last_bit : last_bit;
    acc_or                = byte_accumulator | (8'(bit_val) << bit_position);
    count_inc             = (byte_count == VPW_COUNT_MAX) ? byte_count : byte_count + 8'd1;
    unique case (q_op) inside
      OP_END: begin
        load            = 1'b1;
        result.kind     = KIND_END;
        result.frame_bytes = byte_count;
        byte_count_next = '0;
      end
      OP_SOF: begin
        load                  = 1'b1;
        result.kind           = KIND_START;
        byte_count_next       = '0;
        byte_accumulator_next = '0;
        bit_position_next     = VPW_BIT_POS_TOP;
        last_bit_next         = 1'b1;
        last_symbol_next      = 1'b1;
      end
      OP_LONG, OP_SHORT: begin
        last_bit_next    = bit_val;
        last_symbol_next = sym;
        if (bit_position == 3'd0) begin
          load                  = 1'b1;
          result.kind           = KIND_BYTE;
          result.data_byte      = acc_or;
          result.frame_bytes    = count_inc;
          byte_count_next       = count_inc;
          byte_accumulator_next = '0;
          bit_position_next     = VPW_BIT_POS_TOP;
        end else begin
          byte_accumulator_next = acc_or;
          bit_position_next     = bit_position - 3'd1;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  // symbol history and byte assembly
  always_ff @(posedge clk) begin
    if (rst) begin
      last_bit         <= 1'b1;
      last_symbol      <= 1'b1;
      bit_position     <= VPW_BIT_POS_TOP;
      byte_accumulator <= '0;
      byte_count       <= '0;
    end else if (pop) begin
      last_bit         <= last_bit_next;
      last_symbol      <= last_symbol_next;
      bit_position     <= bit_position_next;
      byte_accumulator <= byte_accumulator_next;
      byte_count       <= byte_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && load) begin
      out_data <= result;
    end
  end

  `VPW_ASSERT_NEXT(a_byte_restarts_position, clk, rst,
                   pop && load && result.kind == KIND_BYTE, bit_position == VPW_BIT_POS_TOP)

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import vpw_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam logic [VPW_REG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef enum logic {
    SYM_LONG  = 1'b0,
    SYM_SHORT = 1'b1
  } sym_t;

  typedef enum int {
    PICK_SOF,
    PICK_LONG,
    PICK_SHORT,
    PICK_NOISE
  } pick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  vpw_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  vpw_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [VPW_REG_IDX_W-1:0] cfg_index = '0;
  logic [VPW_TS_W-1:0] cfg_data = '0;

  // decoder state as the testbench sees it
  vpw_cfg_t win;
  logic armed = 1'b0;
  logic [VPW_TS_W-1:0] prev_stamp = '0;
  logic held_bit = 1'b1;
  sym_t held_sym = SYM_SHORT;
  logic [2:0] bit_slot = VPW_BIT_POS_TOP;
  logic [7:0] shift_byte = '0;
  logic [7:0] frame_len = '0;

  vpw_out_t decoded_q [$];
  logic [VPW_TS_W-1:0] bus_time = '0;
  logic calm = 1'b0;

  int fail_count = 0;
  int sent_count = 0;
  int reg_writes = 0;
  int results_seen = 0;
  int bytes_seen = 0;
  int starts_seen = 0;
  int ends_seen = 0;

  vpw_pulse_width_decoder dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 24);
  end

  function automatic vpw_cfg_t reset_windows();
    return '{sof_min: VPW_SOF_MIN_RST, sof_max: VPW_SOF_MAX_RST,
             long_min: VPW_LONG_MIN_RST, long_max: VPW_LONG_MAX_RST,
             short_min: VPW_SHORT_MIN_RST, short_max: VPW_SHORT_MAX_RST,
             counter_modulus: VPW_MODULUS_RST};
  endfunction

  function automatic logic in_win(logic [15:0] w, logic [15:0] lo, logic [15:0] hi);
    return (w > lo) && (w <= hi);
  endfunction

  // expected decoder behavior for one accepted request
  function automatic void decode_event(vpw_in_t req);
    logic [31:0] span;
    logic [15:0] width;
    logic got_sym;
    sym_t sym;
    logic bit_val;
    if (req.cmd == CMD_TIMEOUT) begin
      decoded_q.push_back('{kind: KIND_END, data_byte: 8'd0, frame_bytes: frame_len});
      armed = 1'b0;
      frame_len = 8'd0;
      return;
    end
    if (!armed) begin
      armed = 1'b1;
    end else begin
      // width since the previous edge, wrapping at the modulus
      if (req.timestamp < prev_stamp) begin
        span = {16'd0, req.timestamp} + win.counter_modulus - prev_stamp;
      end else begin
        span = req.timestamp - prev_stamp;
      end
      width = span[15:0];
      got_sym = 1'b0;
      sym = SYM_SHORT;
      // sof wins over long, long over short
      if (in_win(width, win.sof_min, win.sof_max)) begin
        frame_len = 8'd0;
        shift_byte = 8'd0;
        bit_slot = VPW_BIT_POS_TOP;
        held_bit = 1'b1;
        held_sym = SYM_SHORT;
        decoded_q.push_back('{kind: KIND_START, data_byte: 8'd0, frame_bytes: 8'd0});
      end else if (in_win(width, win.long_min, win.long_max)) begin
        got_sym = 1'b1;
        sym = SYM_LONG;
      end else if (in_win(width, win.short_min, win.short_max)) begin
        got_sym = 1'b1;
        sym = SYM_SHORT;
      end
      // same symbol length flips the bit, other length repeats it
      if (got_sym) begin
        bit_val = (sym == held_sym) ? ~held_bit : held_bit;
        held_bit = bit_val;
        held_sym = sym;
        shift_byte[bit_slot] = shift_byte[bit_slot] | bit_val;
        if (bit_slot == 3'd0) begin
          if (frame_len != VPW_COUNT_MAX) frame_len++;
          decoded_q.push_back('{kind: KIND_BYTE, data_byte: shift_byte,
                                frame_bytes: frame_len});
          shift_byte = 8'd0;
          bit_slot = VPW_BIT_POS_TOP;
        end else begin
          bit_slot--;
        end
      end
    end
    prev_stamp = req.timestamp;
  endfunction

  // result checker
  always @(posedge clk) begin : check_results
    vpw_out_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      case (out_data.kind)
        KIND_BYTE: bytes_seen++;
        KIND_START: starts_seen++;
        KIND_END: ends_seen++;
        default: ;
      endcase
      if (decoded_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual kind %0d data %02h count %0d",
                 $time, out_data.kind, out_data.data_byte, out_data.frame_bytes);
        fail_count++;
      end else begin
        want = decoded_q.pop_front();
        if (out_data.kind !== want.kind) begin
          $display("%0t: kind mismatch, expected %0d actual %0d",
                   $time, want.kind, out_data.kind);
          fail_count++;
        end
        if (out_data.data_byte !== want.data_byte) begin
          $display("%0t: data_byte mismatch, expected %02h actual %02h",
                   $time, want.data_byte, out_data.data_byte);
          fail_count++;
        end
        if (out_data.frame_bytes !== want.frame_bytes) begin
          $display("%0t: frame_bytes mismatch, expected %0d actual %0d",
                   $time, want.frame_bytes, out_data.frame_bytes);
          fail_count++;
        end
      end
    end
  end

  // one request, with random idle cycles ahead of it
  task automatic send_event(input vpw_in_t req);
    if (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(99) < 24);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    decode_event(req);
    sent_count++;
  endtask

  task automatic edge_after(input logic [15:0] width);
    bus_time += width;
    send_event('{cmd: CMD_EDGE, timestamp: bus_time});
  endtask

  task automatic send_timeout();
    send_event('{cmd: CMD_TIMEOUT, timestamp: 16'($urandom)});
  endtask

  function automatic logic [15:0] pick_width(pick_t p);
    logic [15:0] lo;
    logic [15:0] hi;
    case (p)
      PICK_SOF: begin
        lo = win.sof_min;
        hi = win.sof_max;
      end
      PICK_LONG: begin
        lo = win.long_min;
        hi = win.long_max;
      end
      PICK_SHORT: begin
        lo = win.short_min;
        hi = win.short_max;
      end
      default: return 16'($urandom);
    endcase
    if (lo >= hi) return 16'($urandom);
    // mostly inside the window, sometimes right on its bounds
    case ($urandom_range(19))
      0: return lo;
      1: return hi;
      2: return hi + 16'd1;
      default: return 16'($urandom_range(hi, lo + 1));
    endcase
  endfunction

  // arm, start of frame, symbols, then timeout (only at random when the frame is cut)
  task automatic send_frame(input int nbytes, input int noise_pct, input int cut_at);
    int n_sym;
    n_sym = nbytes * 8;
    if (!armed) edge_after(16'($urandom));
    edge_after(pick_width(PICK_SOF));
    for (int i = 0; i < n_sym && i != cut_at; i++) begin
      if ($urandom_range(99) < noise_pct) edge_after(pick_width(PICK_NOISE));
      edge_after(pick_width($urandom_range(1) ? PICK_LONG : PICK_SHORT));
    end
    if (cut_at < 0 || $urandom_range(1)) send_timeout();
  endtask

  // wait for every expected result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [VPW_REG_IDX_W-1:0] idx,
                           input logic [VPW_TS_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SOF_MIN: win.sof_min = val;
      REG_SOF_MAX: win.sof_max = val;
      REG_LONG_MIN: win.long_min = val;
      REG_LONG_MAX: win.long_max = val;
      REG_SHORT_MIN: win.short_min = val;
      REG_SHORT_MAX: win.short_max = val;
      REG_COUNTER_MODULUS: win.counter_modulus = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  // idle the block, then write all registers plus the unused index
  task automatic apply_config(input vpw_cfg_t c);
    drain();
    write_reg(REG_NONE, 16'($urandom));
    write_reg(REG_SOF_MIN, c.sof_min);
    write_reg(REG_SOF_MAX, c.sof_max);
    write_reg(REG_LONG_MIN, c.long_min);
    write_reg(REG_LONG_MAX, c.long_max);
    write_reg(REG_SHORT_MIN, c.short_min);
    write_reg(REG_SHORT_MAX, c.short_max);
    write_reg(REG_COUNTER_MODULUS, c.counter_modulus);
    cfg_valid <= 1'b0;
  endtask

  // reset windows: idle timeout, arming edge, window bounds, timer wrap
  task automatic test_idle_and_windows();
    bus_time = 16'hFFC0;
    send_timeout();
    edge_after(16'd5);
    edge_after(16'd200);
    edge_after(16'd164);
    edge_after(16'd239);
    edge_after(16'd240);
    edge_after(16'd163);
    edge_after(16'd97);
    edge_after(16'd96);
    edge_after(16'd35);
    edge_after(16'd34);
    edge_after(16'd0);
    repeat (4) edge_after(16'd64);
    send_timeout();
    send_timeout();
    edge_after(16'd1000);
    edge_after(16'd180);
    send_timeout();
  endtask

  // overlapping windows, full-range windows and empty windows
  task automatic test_register_writes();
    vpw_cfg_t c;
    c = '{sof_min: 16'd50, sof_max: 16'd150, long_min: 16'd40, long_max: 16'd200,
          short_min: 16'd0, short_max: 16'hFFFF, counter_modulus: 16'hFFFF};
    apply_config(c);
    edge_after(16'd10);
    edge_after(16'd1);
    edge_after(16'd40);
    edge_after(16'd50);
    edge_after(16'd51);
    edge_after(16'd150);
    edge_after(16'd151);
    edge_after(16'd200);
    edge_after(16'd201);
    edge_after(16'hFFFF);
    repeat (8) edge_after(16'($urandom));
    // everything but a zero width is a frame start
    c = '{sof_min: 16'd0, sof_max: 16'hFFFF, long_min: 16'd0, long_max: 16'hFFFF,
          short_min: 16'd0, short_max: 16'hFFFF, counter_modulus: 16'hFFFF};
    apply_config(c);
    edge_after(16'd0);
    repeat (6) edge_after(16'($urandom));
    // no frame start possible, every nonzero width is long
    c.sof_min = 16'hFFFF;
    c.sof_max = 16'd0;
    apply_config(c);
    repeat (16) edge_after(16'($urandom));
    // only short symbols left
    c.long_min = 16'hFFFF;
    c.long_max = 16'd0;
    apply_config(c);
    repeat (16) edge_after(16'($urandom));
    send_timeout();
  endtask

  // stamps below the previous one at several modulus values
  task automatic test_modulus_wrap();
    vpw_cfg_t c;
    logic [15:0] mods [5];
    mods = '{16'd1, 16'hFFFF, 16'h8000, 16'd2, 16'($urandom_range(65535, 1))};
    c = '{sof_min: 16'd40000, sof_max: 16'd60000, long_min: 16'd20000, long_max: 16'd40000,
          short_min: 16'd0, short_max: 16'd20000, counter_modulus: 16'hFFFF};
    foreach (mods[m]) begin
      c.counter_modulus = mods[m];
      apply_config(c);
      repeat (20) send_event('{cmd: CMD_EDGE, timestamp: 16'($urandom)});
    end
    send_timeout();
  endtask

  // one long clean frame under the reset windows
  task automatic test_long_frame();
    apply_config(reset_windows());
    send_frame(16, 0, -1);
  endtask

  // random frames, broken frames and noise under several window settings
  task automatic test_random_frames();
    vpw_cfg_t c;
    int first;
    int scale;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase) inside
        0: c = reset_windows();
        1, 2: begin
          scale = (phase == 1) ? 300 : 6000;
          c.short_min = 16'($urandom_range(scale));
          c.short_max = c.short_min + 16'($urandom_range(scale, 1));
          c.long_min = c.short_max;
          c.long_max = c.long_min + 16'($urandom_range(scale, 1));
          c.sof_min = c.long_max;
          c.sof_max = c.sof_min + 16'($urandom_range(scale, 1));
          c.counter_modulus = (phase == 1) ? 16'hFFFF : 16'($urandom_range(65535, 60000));
        end
        3: c = '{sof_min: 16'd400, sof_max: 16'hFFFF, long_min: 16'd120, long_max: 16'd400,
                 short_min: 16'd0, short_max: 16'd120, counter_modulus: 16'd1};
        default: begin
          c = vpw_cfg_t'(112'({$urandom, $urandom, $urandom, $urandom}));
          c.counter_modulus = 16'($urandom_range(65535, 1));
        end
      endcase
      apply_config(c);
      calm = (phase == 2);
      first = sent_count;
      while (sent_count - first < 60) begin
        case ($urandom_range(19)) inside
          0, 1: repeat ($urandom_range(6, 1)) edge_after(pick_width(PICK_NOISE));
          2: send_timeout();
          3, 4, 5: send_frame($urandom_range(3, 1), 10, $urandom_range(20, 0));
          default: send_frame($urandom_range(4, 1), 3, -1);
        endcase
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    win = reset_windows();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_idle_and_windows();
    test_register_writes();
    test_modulus_wrap();
    test_long_frame();
    test_random_frames();
    drain();
    $display("tb: %0d requests sent, %0d register writes, %0d results compared",
             sent_count, reg_writes, results_seen);
    $display("tb: %0d data bytes, %0d frame starts, %0d frame ends",
             bytes_seen, starts_seen, ends_seen);
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #(10_000_000);
    $display("%0t: run did not finish in time", $time);
    $display("tb: errors");
    $finish;
  end

endmodule

FILE: vpw_pulse_width_decoder.f
+incdir+rtl
rtl/vpw_pkg.sv
rtl/vpw_queue.sv
rtl/vpw_front.sv
rtl/vpw_back.sv
rtl/vpw_pulse_width_decoder.sv
tb/tb.sv
